// ===== src/utf8d_pkg.sv =====
// Shared types and byte constants for the UTF-8 stream decoder.
package utf8d_pkg;

    // Field widths of one transfer
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 31;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned NEED_W  = 3;

    // Byte class boundaries
    localparam logic [BYTE_W-1:0] CONT_MIN   = 8'h80;  // lowest continuation byte
    localparam logic [BYTE_W-1:0] LEAD_MIN   = 8'hC2;  // lowest valid multi-byte lead
    localparam logic [BYTE_W-1:0] LEAD_3     = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4     = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD_5     = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD_6     = 8'hFC;
    localparam logic [BYTE_W-1:0] LEAD_END   = 8'hFE;  // first invalid lead at the top

    // Lower bound on the second byte after the shortest-form leads
    localparam logic [BYTE_W-1:0] MIN_AFTER_E0 = 8'hA0;
    localparam logic [BYTE_W-1:0] MIN_AFTER_F0 = 8'h90;
    localparam logic [BYTE_W-1:0] MIN_AFTER_F8 = 8'h88;
    localparam logic [BYTE_W-1:0] MIN_AFTER_FC = 8'h84;

    // Result status codes
    typedef enum logic [1:0] {
        ST_CHAR      = 2'd0,
        ST_INVALID   = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    // One input byte as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_in_item;

    // One result transfer
    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        t_status            status;
        logic               end_of_string;
        logic [COUNT_W-1:0] char_count;
    } t_result;

endpackage

// ===== src/utf8_stream_decoder.sv =====
// UTF-8 stream decoder (one- to six-byte forms), top level.
// An input transfer is held in the input register until it is decoded into the result register.
// Throughput: one byte per cycle when not stalled; set by the single decode pass
// between the input and result registers, with the sequence state updated in that pass.
// Reset (synchronous, active low) empties both registers, clears the sequence
// state and the character count, and ends any discard of a bad string.
module utf8_stream_decoder
    import utf8d_pkg::*;
#(
    parameter int unsigned MAX_STRING_CHARS = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic               i_last_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [CP_W-1:0]    o_code_point,
    output logic [1:0]         o_status,
    output logic               o_end_of_string,
    output logic [COUNT_W-1:0] o_char_count
);

    logic     item_valid;
    t_in_item item;
    logic     out_free;
    logic     fire;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    // A byte moves into the core whenever the result register can take a result
    assign fire = item_valid & out_free;

    utf8d_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_advance    (fire),
        .o_stall      (o_stall),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    utf8d_core #(
        .MAX_STRING_CHARS (MAX_STRING_CHARS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    utf8d_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_code_point    = out_res.code_point;
    assign o_status        = out_res.status;
    assign o_end_of_string = out_res.end_of_string;
    assign o_char_count    = out_res.char_count;

endmodule

// ===== src/utf8d_in_stage.sv =====
// Input register stage: captures one byte per transfer and holds it until the core takes it.
module utf8d_in_stage
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_advance,
    output logic              o_stall,
    output logic              o_item_valid,
    output t_in_item          o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    // Stall only while a held byte cannot move on
    assign o_stall = r_valid & ~i_advance;
    assign accept  = i_valid & ~o_stall;
    assign n_valid = accept | (r_valid & ~i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.data_byte <= i_data_byte;
            r_item.last_byte <= i_last_byte;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

// ===== src/utf8d_core.sv =====
// Decoder core: sequence state and per-byte decode between input and result registers.
module utf8d_core
    import utf8d_pkg::*;
#(
    parameter int unsigned MAX_STRING_CHARS = 65535
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_item i_item,
    output logic     o_res_valid,
    output t_result  o_res
);

    localparam logic [COUNT_W-1:0] CountLimit =
        (MAX_STRING_CHARS < 32'd65535) ? COUNT_W'(MAX_STRING_CHARS) : {COUNT_W{1'b1}};

    logic [NEED_W-1:0]  r_need, n_need;
    logic [CP_W-1:0]    r_acc, n_acc;
    logic [BYTE_W-1:0]  r_min, n_min;
    logic               r_at_second, n_at_second;
    logic               r_discard, n_discard;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [BYTE_W-1:0]  b;
    logic               last;
    logic [NEED_W-1:0]  lead_need;
    logic [BYTE_W-1:0]  lead_mask;
    logic [BYTE_W-1:0]  lead_min;
    logic [CP_W-1:0]    acc_shift;
    logic [NEED_W-1:0]  need_dec;
    logic [COUNT_W-1:0] count_inc;
    logic               is_err;
    logic               is_char;
    logic               is_trunc;
    logic               is_lead;
    logic               is_step;
    logic [CP_W-1:0]    char_cp;

    assign b         = i_item.data_byte;
    assign last      = i_item.last_byte;
    assign acc_shift = {r_acc[CP_W-7:0], b[5:0]};
    assign need_dec  = r_need - NEED_W'(1);
    assign count_inc = (r_count < CountLimit) ? r_count + COUNT_W'(1) : r_count;

    // Lead byte decode: sequence length, payload mask, overlong bound
    always_comb begin
        lead_need = NEED_W'(1);
        lead_mask = 8'h1F;
        lead_min  = CONT_MIN;
        priority if (b < LEAD_3) begin
            lead_need = NEED_W'(1);
            lead_mask = 8'h1F;
        end else if (b < LEAD_4) begin
            lead_need = NEED_W'(2);
            lead_mask = 8'h0F;
            if (b == LEAD_3) lead_min = MIN_AFTER_E0;
        end else if (b < LEAD_5) begin
            lead_need = NEED_W'(3);
            lead_mask = 8'h07;
            if (b == LEAD_4) lead_min = MIN_AFTER_F0;
        end else if (b < LEAD_6) begin
            lead_need = NEED_W'(4);
            lead_mask = 8'h03;
            if (b == LEAD_5) lead_min = MIN_AFTER_F8;
        end else begin
            lead_need = NEED_W'(5);
            lead_mask = 8'h01;
            if (b == LEAD_6) lead_min = MIN_AFTER_FC;
        end
    end

    // Classify the byte against the current sequence state
    always_comb begin
        is_err   = 1'b0;
        is_char  = 1'b0;
        is_trunc = 1'b0;
        is_lead  = 1'b0;
        is_step  = 1'b0;
        char_cp  = '0;
        if (r_need == '0) begin
            if (!b[7]) begin
                is_char = 1'b1;
                char_cp = CP_W'(b);
            end else if (b < LEAD_MIN || b >= LEAD_END) begin
                is_err = 1'b1;
            end else begin
                is_lead  = 1'b1;
                is_trunc = last;
            end
        end else if (b[7:6] != 2'b10) begin
            is_err = 1'b1;
        end else if (r_at_second && b < r_min) begin
            is_err = 1'b1;
        end else if (need_dec == '0) begin
            is_char = 1'b1;
            char_cp = acc_shift;
        end else begin
            is_step  = 1'b1;
            is_trunc = last;
        end
    end

    // Next state and result
    always_comb begin
        n_need      = r_need;
        n_acc       = r_acc;
        n_min       = r_min;
        n_at_second = r_at_second;
        n_discard   = r_discard;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res.code_point    = '0;
        o_res.status        = ST_CHAR;
        o_res.end_of_string = 1'b1;
        o_res.char_count    = r_count;

        if (i_fire) begin
            if (r_discard) begin
                // Dropping the rest of a bad string up to its last byte
                if (last) begin
                    n_discard   = 1'b0;
                    n_need      = '0;
                    n_acc       = '0;
                    n_min       = CONT_MIN;
                    n_at_second = 1'b0;
                    n_count     = '0;
                end
            end else if (is_err) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_INVALID;
                n_need       = '0;
                n_acc        = '0;
                n_min        = CONT_MIN;
                n_at_second  = 1'b0;
                n_count      = '0;
                n_discard    = ~last;
            end else if (is_char) begin
                o_res_valid         = 1'b1;
                o_res.code_point    = char_cp;
                o_res.end_of_string = last;
                o_res.char_count    = count_inc;
                n_need      = '0;
                n_acc       = '0;
                n_min       = CONT_MIN;
                n_at_second = 1'b0;
                n_count     = last ? '0 : count_inc;
            end else if (is_trunc) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_TRUNCATED;
                n_need       = '0;
                n_acc        = '0;
                n_min        = CONT_MIN;
                n_at_second  = 1'b0;
                n_count      = '0;
            end else if (is_lead) begin
                n_need      = lead_need;
                n_acc       = CP_W'(b & lead_mask);
                n_min       = lead_min;
                n_at_second = 1'b1;
            end else if (is_step) begin
                n_need      = need_dec;
                n_acc       = acc_shift;
                n_at_second = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need      <= '0;
            r_acc       <= '0;
            r_min       <= CONT_MIN;
            r_at_second <= 1'b0;
            r_discard   <= 1'b0;
            r_count     <= '0;
        end else begin
            r_need      <= n_need;
            r_acc       <= n_acc;
            r_min       <= n_min;
            r_at_second <= n_at_second;
            r_discard   <= n_discard;
            r_count     <= n_count;
        end
    end

endmodule

// ===== src/utf8d_out_stage.sv =====
// Result register: holds one result transfer until the receiver takes it.
module utf8d_out_stage
    import utf8d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // Free when empty or being taken in this cycle
    assign o_free  = ~r_valid | ~i_stall;
    assign n_valid = i_load | (r_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== src/utf8d_checker.sv =====
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
module utf8d_checker
    import utf8d_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [CP_W-1:0]    o_code_point,
    input logic [1:0]         o_status,
    input logic               o_end_of_string,
    input logic [COUNT_W-1:0] o_char_count
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_point) && $stable(o_status)
            && $stable(o_end_of_string) && $stable(o_char_count))
        else $error("result changed while stalled");

    // Input only stalls behind a full result register that is itself stalled
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // Error and truncation results close the string and carry no code point
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_INVALID || o_status == ST_TRUNCATED)
            |-> o_end_of_string && (o_code_point == '0))
        else $error("error result without end of string or with a code point");

    // A decoded character always counts itself
    a_char_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_CHAR |-> o_char_count != '0)
        else $error("character result with zero count");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (.*);

// ===== tb/utf8_stream_decoder_test.sv =====
// Self-checking testbench for the UTF-8 stream decoder: scoreboard class and drivers.
`timescale 1ns / 1ps

module utf8_stream_decoder_test;
    import utf8d_pkg::*;

    localparam int unsigned MAX_CHARS   = 65535;
    localparam int unsigned COUNT_LIMIT = (MAX_CHARS < 65535) ? MAX_CHARS : 65535;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned LONG_STRING = 300;

    // Directed bytes, {last_byte, data_byte}
    localparam logic [8:0] DIRECTED [23] = '{
        9'h1_00,                                         // lowest ASCII, alone
        9'h0_7F, 9'h0_C2, 9'h1_80,                       // top ASCII, lowest two-byte
        9'h0_FD, 9'h0_BF, 9'h0_BF, 9'h0_BF, 9'h0_BF, 9'h1_BF, // largest six-byte
        9'h0_80, 9'h0_41, 9'h1_42,                       // bad lead, rest dropped
        9'h1_FF,                                         // bad lead on the last byte
        9'h1_C1,                                         // overlong two-byte lead
        9'h0_E0, 9'h1_9F,                                // overlong three-byte form
        9'h0_C3, 9'h0_41, 9'h1_42,                       // non-continuation byte
        9'h0_F0, 9'h1_90,                                // string ends mid-sequence
        9'h1_E5                                          // string ends on a lead
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [BYTE_W-1:0]  i_data_byte;
    logic               i_last_byte;
    logic               o_valid;
    logic               i_stall;
    logic [CP_W-1:0]    o_code_point;
    logic [1:0]         o_status;
    logic               o_end_of_string;
    logic [COUNT_W-1:0] o_char_count;

    int unsigned cycles;
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          hold_req;
    int unsigned hold_left;

    // Predicts decoder results and checks them in order
    class utf8_scoreboard;
        logic [NEED_W-1:0]  need_left;
        logic [CP_W-1:0]    acc;
        logic [BYTE_W-1:0]  second_min;
        bit                 at_second;
        bit                 skipping;
        logic [COUNT_W-1:0] chars;
        t_result            expected_results[$];
        int unsigned        failures;
        int unsigned        live_bytes;
        int unsigned        skipped_bytes;
        int unsigned        n_chars;
        int unsigned        n_invalid;
        int unsigned        n_truncated;

        function new();
            skipping = 0;
            close_string();
        endfunction

        function void clear_sequence();
            need_left  = '0;
            acc        = '0;
            second_min = CONT_MIN;
            at_second  = 0;
        endfunction

        function void close_string();
            clear_sequence();
            chars = '0;
        endfunction

        function void push_result(input logic [CP_W-1:0] cp, input t_status st, input bit eos);
            t_result r;
            r.code_point    = cp;
            r.status        = st;
            r.end_of_string = eos;
            r.char_count    = chars;
            expected_results.push_back(r);
        endfunction

        function void emit_char(input logic [CP_W-1:0] cp, input bit l);
            if (chars < COUNT_LIMIT) chars++;
            push_result(cp, ST_CHAR, l);
            if (l) close_string();
        endfunction

        function void emit_error(input bit l);
            push_result('0, ST_INVALID, 1'b1);
            close_string();
            skipping = !l;
        endfunction

        function void emit_truncated();
            push_result('0, ST_TRUNCATED, 1'b1);
            close_string();
        endfunction

        // Work out the result, if any, of one accepted byte
        function void note_input(input logic [BYTE_W-1:0] b, input logic l);
            logic [CP_W-1:0]   cp;
            logic [BYTE_W-1:0] floor_b;
            logic [BYTE_W-1:0] mask;
            logic [NEED_W-1:0] need;
            if (skipping) begin
                skipped_bytes++;
                if (l) begin
                    skipping = 0;
                    close_string();
                end
                return;
            end
            live_bytes++;
            // lead byte
            if (need_left == 0) begin
                if (b < CONT_MIN) begin
                    emit_char(CP_W'(b), l);
                    return;
                end
                if (b < LEAD_MIN || b >= LEAD_END) begin
                    emit_error(l);
                    return;
                end
                floor_b = CONT_MIN;
                if (b < LEAD_3) begin
                    need = NEED_W'(1); mask = 8'h1F;
                end else if (b < LEAD_4) begin
                    need = NEED_W'(2); mask = 8'h0F;
                    if (b == LEAD_3) floor_b = MIN_AFTER_E0;
                end else if (b < LEAD_5) begin
                    need = NEED_W'(3); mask = 8'h07;
                    if (b == LEAD_4) floor_b = MIN_AFTER_F0;
                end else if (b < LEAD_6) begin
                    need = NEED_W'(4); mask = 8'h03;
                    if (b == LEAD_5) floor_b = MIN_AFTER_F8;
                end else begin
                    need = NEED_W'(5); mask = 8'h01;
                    if (b == LEAD_6) floor_b = MIN_AFTER_FC;
                end
                need_left  = need;
                acc        = CP_W'(b & mask);
                second_min = floor_b;
                at_second  = 1;
                if (l) emit_truncated();
                return;
            end
            // continuation byte
            if (b[7:6] != 2'b10 || (at_second && b < second_min)) begin
                emit_error(l);
                return;
            end
            acc       = {acc[CP_W-7:0], b[5:0]};
            need_left = need_left - 1'b1;
            at_second = 0;
            if (need_left == 0) begin
                cp = acc;
                clear_sequence();
                emit_char(cp, l);
            end else if (l) begin
                emit_truncated();
            end
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected result cp=%h st=%0d eos=%0d cnt=%0d",
                             got.code_point, got.status, got.end_of_string, got.char_count);
                return;
            end
            want = expected_results.pop_front();
            case (want.status)
                ST_CHAR:    n_chars++;
                ST_INVALID: n_invalid++;
                default:    n_truncated++;
            endcase
            if (got !== want) begin
                failures++;
                if (failures <= 10)
                    $display({"ERROR: expected cp=%h st=%0d eos=%0d cnt=%0d,",
                              " got cp=%h st=%0d eos=%0d cnt=%0d"},
                             want.code_point, want.status, want.end_of_string, want.char_count,
                             got.code_point, got.status, got.end_of_string, got.char_count);
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    utf8_scoreboard sb;

    utf8_stream_decoder #(
        .MAX_STRING_CHARS(MAX_CHARS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_code_point   (o_code_point),
        .o_status       (o_status),
        .o_end_of_string(o_end_of_string),
        .o_char_count   (o_char_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_req  = 0;
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Transfer monitor and run limit
    always @(posedge i_clk) begin
        t_result got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_input(i_data_byte, i_last_byte);
            if (o_valid && !i_stall) begin
                got.code_point    = o_code_point;
                got.status        = t_status'(o_status);
                got.end_of_string = o_end_of_string;
                got.char_count    = o_char_count;
                sb.check_result(got);
            end
        end
    end

    // Offer one byte, with a random gap first, and wait for its transfer
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit l);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= l;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Stop offering and wait for every pending result
    task automatic wait_quiet();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] second_floor(input logic [BYTE_W-1:0] lead);
        case (lead)
            LEAD_3:  return MIN_AFTER_E0;
            LEAD_4:  return MIN_AFTER_F0;
            LEAD_5:  return MIN_AFTER_F8;
            LEAD_6:  return MIN_AFTER_FC;
            default: return CONT_MIN;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_lead(input int n);
        case (n)
            1:       return 8'($urandom_range(CONT_MIN - 1));
            2:       return 8'($urandom_range(LEAD_3 - 1, LEAD_MIN));
            3:       return 8'($urandom_range(LEAD_4 - 1, LEAD_3));
            4:       return 8'($urandom_range(LEAD_5 - 1, LEAD_4));
            5:       return 8'($urandom_range(LEAD_6 - 1, LEAD_5));
            default: return 8'($urandom_range(LEAD_END - 1, LEAD_6));
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 1;
        if (r < 65) return 2;
        if (r < 80) return 3;
        if (r < 90) return 4;
        if (r < 95) return 5;
        return 6;
    endfunction

    // Send the first k bytes of an n-byte character, shortest form honoured
    task automatic send_char(input int n, input int k, input bit l);
        logic [BYTE_W-1:0] lead;
        lead = pick_lead(n);
        send_byte(lead, l && k == 1);
        for (int j = 1; j < k; j++)
            send_byte(8'($urandom_range(8'hBF, (j == 1) ? second_floor(lead) : CONT_MIN)),
                      l && j == k - 1);
    endtask

    // One string: mostly well-formed, else broken, cut short or noise
    task automatic send_string(input int max_chars);
        int                nchars;
        int                kind;
        int                n;
        int                tail;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] lead;
        nchars = $urandom_range(max_chars, 1);
        kind   = $urandom_range(99);
        if (kind < 70) begin
            for (int i = 0; i < nchars; i++) begin
                n = pick_length();
                send_char(n, n, i == nchars - 1);
            end
        end else if (kind < 92) begin
            for (int i = 0; i < nchars - 1; i++) begin
                n = pick_length();
                send_char(n, n, 1'b0);
            end
            tail = $urandom_range(4);
            if (kind < 85) begin
                // bad byte: stray lead, non-continuation or overlong second byte
                case ($urandom_range(2))
                    0: b = $urandom_range(1) ? 8'($urandom_range(LEAD_MIN - 1, CONT_MIN))
                                             : 8'($urandom_range(8'hFF, LEAD_END));
                    1: begin
                        n = $urandom_range(6, 2);
                        send_char(n, $urandom_range(n - 1, 1), 1'b0);
                        b = 8'($urandom_range(255));
                        if (b[7:6] == 2'b10) b[6] = 1'b1;
                    end
                    default: begin
                        case ($urandom_range(3))
                            0:       lead = LEAD_3;
                            1:       lead = LEAD_4;
                            2:       lead = LEAD_5;
                            default: lead = LEAD_6;
                        endcase
                        send_byte(lead, 1'b0);
                        b = 8'($urandom_range(second_floor(lead) - 1, CONT_MIN));
                    end
                endcase
                send_byte(b, tail == 0);
                for (int i = 0; i < tail; i++)
                    send_byte(8'($urandom_range(255)), i == tail - 1);
            end else begin
                // string ends mid-sequence
                n = $urandom_range(6, 2);
                send_char(n, $urandom_range(n - 1, 1), 1'b1);
            end
        end else begin
            for (int i = 0; i < nchars; i++)
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
    endtask

    // Main sequence
    initial begin
        sb          = new();
        cycles      = 0;
        idle_pct    = 19;
        stall_pct   = 19;
        hold_req    = 0;
        hold_left   = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data_byte <= '0;
        i_last_byte <= 1'b0;
        i_stall     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        wait_quiet();

        // random strings with idling on both sides
        while (sb.live_bytes < 350) send_string(8);

        // long receiver hold-off while bytes keep coming
        hold_req = 1;
        for (int i = 0; i < 6; i++) send_string(12);
        wait_quiet();

        // a stretch with no idling at all
        idle_pct  = 0;
        stall_pct = 0;
        while (sb.live_bytes < 700) send_string(8);
        idle_pct  = 19;
        stall_pct = 19;

        // longer strings mixed in
        while (sb.live_bytes < 1250) send_string($urandom_range(3) == 0 ? 30 : 8);
        wait_quiet();

        // close whatever the noise strings left open, then one long plain string
        send_byte(8'h0A, 1'b1);
        for (int i = 0; i < LONG_STRING; i++)
            send_byte(8'($urandom_range(CONT_MIN - 1)), i == LONG_STRING - 1);
        wait_quiet();

        $display("Covered %0d decoded bytes and %0d dropped bytes of bad strings.",
                 sb.live_bytes, sb.skipped_bytes);
        $display("Checked %0d characters, %0d invalid and %0d truncated results.",
                 sb.n_chars, sb.n_invalid, sb.n_truncated);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d failures", sb.failures);
            $display("FAIL");
        end
        $finish;
    end

endmodule
